// ===== src/sett_pkg.sv =====
// ----------------------------------------------------------------------------
// sett_pkg
// shared types, codes, constants and helper functions of the trace table
// ----------------------------------------------------------------------------
package sett_pkg;

	// command codes
	localparam logic [2:0] CMD_SET_TRACE   = 3'd0;
	localparam logic [2:0] CMD_ADD_TRACE   = 3'd1;
	localparam logic [2:0] CMD_CLEAR_TRACE = 3'd2;
	localparam logic [2:0] CMD_DECAY       = 3'd3;
	localparam logic [2:0] CMD_UPDATE      = 3'd4;
	localparam logic [2:0] CMD_READ_WEIGHT = 3'd5;
	localparam logic [2:0] CMD_WRITE_WEIGHT = 3'd6;

	// configuration register indexes
	localparam logic CFG_LEARNING_RATE = 1'b0;
	localparam logic CFG_TILING_COUNT  = 1'b1;

	localparam logic [15:0] LRATE_RESET     = 16'd6554;
	localparam logic [10:0] TCNT_RESET      = 11'd32;
	localparam logic [15:0] MIN_TRACE_RESET = 16'd41;
	localparam logic [15:0] TRACE_MAX       = 16'hFFFF;

	// weight step divider: |delta*alpha*trace| >> 28 over the tiling count
	localparam int DIVIDEND_W = 35;
	localparam int DIVISOR_W  = 11;
	localparam int WSUM_W     = DIVIDEND_W + 2;

	// per-feature word held in the feature memory (list position sits above it)
	typedef struct packed {
		logic signed [31:0] weight;
		logic [15:0]        trace;
		logic               act;
	} feat_t;

	function automatic logic [15:0] clamp16(input logic signed [33:0] v);
		logic [15:0] r;
		if (v < 0)
			r = 16'd0;
		else if (v > 34'sd65535)
			r = TRACE_MAX;
		else
			r = v[15:0];
		return r;
	endfunction

	// max(m+1, (11m+5)/10), saturated; divide by ten through a reciprocal
	function automatic logic [15:0] raise_min(input logic [15:0] m);
		logic [19:0] x;
		logic [39:0] pr;
		logic [19:0] q;
		logic [19:0] lo;
		x  = 20'(m) * 20'd11 + 20'd5;
		pr = 40'(x) * 40'd838861;
		q  = 20'(pr >> 23);
		lo = 20'(m) + 20'd1;
		if (q < lo)
			q = lo;
		if (q > 20'd65535)
			q = 20'd65535;
		return q[15:0];
	endfunction

endpackage

// ===== src/sett_ram.sv =====
// ----------------------------------------------------------------------------
// sett_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module sett_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/sett_div.sv =====
// ----------------------------------------------------------------------------
// sett_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sett_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [sett_pkg::DIVIDEND_W-1:0] dividend,
	input  logic [sett_pkg::DIVISOR_W-1:0]  divisor,
	output logic                            done,
	output logic [sett_pkg::DIVIDEND_W-1:0] quotient
);
	import sett_pkg::*;

	localparam int CW = $clog2(DIVIDEND_W);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  den_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W:0]    trial;
	logic                  take;

	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign take  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= take ? DIVISOR_W'(trial - {1'b0, den_q}) : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== src/sparse_eligibility_trace_table_unit.sv =====
// ----------------------------------------------------------------------------
// sparse_eligibility_trace_table_unit
// weight and trace table with a compact list of active traces
// ----------------------------------------------------------------------------
// walks: set/add trace may first cull the list to make room; decay and the
//   weight update visit every active trace, the update through the bit-serial
//   step divider
// throughput: one command at a time; busy is high while a command is in progress
// reset: after arst_n the feature memory is swept clear with busy high; config
//   writes are taken throughout
// results: done strobes for one cycle; the receiver cannot stall
module sparse_eligibility_trace_table_unit #(
	parameter int STORE_DEPTH = 4096,
	parameter int MAX_ACTIVE  = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	// command transaction
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         command,
	input  logic [11:0]        index,
	input  logic signed [31:0] operand,
	// result transaction
	output logic               done,
	output logic signed [31:0] weight_value,
	output logic               status,
	output logic [10:0]        active_count,
	output logic [15:0]        min_trace_now,
	// configuration write transaction
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [0:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import sett_pkg::*;

	localparam int FA_W  = $clog2(STORE_DEPTH);
	localparam int LA_W  = $clog2(MAX_ACTIVE);
	localparam int CNT_W = $clog2(MAX_ACTIVE + 1);
	localparam int FT_W  = $bits(feat_t);
	localparam int FW_W  = FT_W + LA_W;
	localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_ACTIVE);
	localparam logic [FA_W-1:0]  LAST_CLR = FA_W'(STORE_DEPTH - 1);

	// sequencer states
	typedef enum logic [11:0] {
		S_CLR  = 12'b000000000001,
		S_IDLE = 12'b000000000010,
		S_FRD  = 12'b000000000100,
		S_ROOM = 12'b000000001000,
		S_INS  = 12'b000000010000,
		S_LRD  = 12'b000000100000,
		S_SRD  = 12'b000001000000,
		S_MUL  = 12'b000010000000,
		S_DIV  = 12'b000100000000,
		S_MV   = 12'b001000000000,
		S_MVF  = 12'b010000000000,
		S_NEXT = 12'b100000000000
	} state_t;

	// what the list walk is doing
	typedef enum logic [4:0] {
		MODE_DECAY = 5'b00001,
		MODE_CULL  = 5'b00010,
		MODE_ROOM  = 5'b00100,
		MODE_UPD   = 5'b01000,
		MODE_CLEAR = 5'b10000
	} mode_t;

	state_t state_q;
	mode_t  mode_q;

	logic [FA_W-1:0]  clr_q;
	logic [CNT_W-1:0] total_q;
	logic [15:0]      min_q;
	logic [15:0]      lrate_q;
	logic [10:0]      tcnt_q;
	logic [LA_W-1:0]  loc_q;
	logic             done_q;
	logic             status_q;
	logic signed [31:0] wout_q;

	logic [2:0]         cmd_q;
	logic [FA_W-1:0]    f_q;
	logic signed [31:0] opnd_q;
	logic [15:0]        val_q;
	logic [15:0]        rate_q;
	logic signed [47:0] da_q;
	logic [FA_W-1:0]    sf_q;
	logic [FA_W-1:0]    mv_q;
	logic [FW_W-1:0]    fw_q;
	logic [FW_W-1:0]    sw_q;
	logic signed [63:0] prod_s1;
	logic               neg_q;

	// memory ports
	logic [FA_W-1:0] fr_addr, fw_addr;
	logic            fw_en;
	logic [FW_W-1:0] fw_data, frd;
	logic [LA_W-1:0] lr_addr, lw_addr;
	logic            lw_en;
	logic [FA_W-1:0] lw_data, lrd;

	// divider
	logic                  div_start, div_done;
	logic [DIVIDEND_W-1:0] div_quot;
	logic [DIVIDEND_W-1:0] dividend;
	logic [DIVISOR_W-1:0]  divisor;
	logic [63:0]           abs_p;

	// decoded words
	feat_t            frd_f, fwq_f, swq_f;
	logic [LA_W-1:0]  frd_pos, swq_pos;
	logic             in_range, needs_idx, full;
	logic [FA_W-1:0]  idx_f;
	logic [LA_W-1:0]  last_loc;
	logic signed [33:0] opnd_x, tr_sum;
	logic [15:0]      new_val;
	logic [31:0]      dprod;
	logic [15:0]      decayed;
	logic             drop_scan;
	logic [DIVIDEND_W:0]        qmag;
	logic signed [DIVIDEND_W:0] qs;
	logic signed [WSUM_W-1:0]   wsum;
	logic signed [31:0]         wnew;

	assign frd_f   = feat_t'(frd[FT_W-1:0]);
	assign frd_pos = frd[FW_W-1:FT_W];
	assign fwq_f   = feat_t'(fw_q[FT_W-1:0]);
	assign swq_f   = feat_t'(sw_q[FT_W-1:0]);
	assign swq_pos = sw_q[FW_W-1:FT_W];

	assign in_range  = {20'd0, index} < 32'(STORE_DEPTH);
	assign needs_idx = (command == CMD_SET_TRACE) || (command == CMD_ADD_TRACE) ||
		(command == CMD_CLEAR_TRACE) || (command == CMD_READ_WEIGHT) ||
		(command == CMD_WRITE_WEIGHT);
	assign idx_f     = FA_W'({20'd0, index});
	assign full      = total_q >= MAX_CNT;
	assign last_loc  = LA_W'(total_q - 1'b1);

	// trace value for set and add
	assign opnd_x  = 34'(opnd_q);
	assign tr_sum  = $signed({18'd0, frd_f.trace}) + opnd_x;
	assign new_val = (cmd_q == CMD_ADD_TRACE) ? clamp16(tr_sum) : clamp16(opnd_x);

	// decay product, truncated
	assign dprod   = 32'(frd_f.trace) * 32'(rate_q);
	assign decayed = dprod[31:16];

	// drop decision for the entry under the list walk
	always_comb begin
		unique case (mode_q)
			MODE_DECAY: drop_scan = decayed < min_q;
			MODE_CULL:  drop_scan = frd_f.trace < min_q;
			MODE_ROOM:  drop_scan = 1'b1;
			default:    drop_scan = 1'b0;
		endcase
	end

	// weight step: magnitude over the divider, sign restored, saturating add
	assign abs_p     = prod_s1[63] ? 64'(-prod_s1) : 64'(prod_s1);
	assign dividend  = abs_p[28 +: DIVIDEND_W];
	assign divisor   = (tcnt_q == 11'd0) ? 11'd1 : tcnt_q;
	assign div_start = (state_q == S_MUL);
	assign qmag      = {1'b0, div_quot};
	assign qs        = neg_q ? -$signed(qmag) : $signed(qmag);
	assign wsum      = WSUM_W'(swq_f.weight) + WSUM_W'(qs);

	always_comb begin
		if (!wsum[WSUM_W-1] && (|wsum[WSUM_W-2:31]))
			wnew = 32'sh7FFFFFFF;
		else if (wsum[WSUM_W-1] && !(&wsum[WSUM_W-2:31]))
			wnew = 32'sh80000000;
		else
			wnew = wsum[31:0];
	end

	// memory control
	always_comb begin
		feat_t wf;
		wf      = frd_f;
		fr_addr = sf_q;
		fw_en   = 1'b0;
		fw_addr = sf_q;
		fw_data = frd;
		lr_addr = loc_q;
		lw_en   = 1'b0;
		lw_addr = loc_q;
		lw_data = f_q;
		unique case (state_q)
			S_CLR: begin
				fw_en   = 1'b1;
				fw_addr = clr_q;
				fw_data = '0;
			end
			S_IDLE: begin
				fr_addr = idx_f;
				lr_addr = (command == CMD_DECAY) ? last_loc : '0;
			end
			S_FRD: begin
				fw_addr = f_q;
				unique case (cmd_q)
					CMD_WRITE_WEIGHT: begin
						wf.weight = opnd_q;
						fw_en     = 1'b1;
					end
					CMD_CLEAR_TRACE: begin
						wf.trace = '0;
						wf.act   = 1'b0;
						fw_en    = frd_f.act;
						lr_addr  = last_loc;
					end
					CMD_SET_TRACE, CMD_ADD_TRACE: begin
						wf.trace = new_val;
						fw_en    = frd_f.act;
					end
					default: ;
				endcase
				fw_data = {frd_pos, wf};
			end
			S_ROOM: lr_addr = last_loc;
			S_INS: begin
				wf       = fwq_f;
				wf.trace = val_q;
				wf.act   = 1'b1;
				fw_en    = 1'b1;
				fw_addr  = f_q;
				fw_data  = {LA_W'(total_q), wf};
				lw_en    = 1'b1;
				lw_addr  = LA_W'(total_q);
				lw_data  = f_q;
			end
			S_LRD: fr_addr = lrd;
			S_SRD: begin
				if (drop_scan) begin
					wf.trace = '0;
					wf.act   = 1'b0;
					fw_en    = 1'b1;
					lr_addr  = last_loc;
				end else if (mode_q == MODE_DECAY) begin
					wf.trace = decayed;
					fw_en    = 1'b1;
				end
				fw_data = {frd_pos, wf};
			end
			S_MV: begin
				lw_en   = 1'b1;
				lw_data = lrd;
				fr_addr = lrd;
			end
			S_MVF: begin
				fw_en   = 1'b1;
				fw_addr = mv_q;
				fw_data = {loc_q, frd_f};
			end
			S_NEXT: lr_addr = (mode_q == MODE_UPD) ? LA_W'(loc_q + 1'b1) : LA_W'(loc_q - 1'b1);
			S_DIV: begin
				wf        = swq_f;
				wf.weight = wnew;
				fw_en     = div_done;
				fw_data   = {swq_pos, wf};
			end
			default: ;
		endcase
	end

	// control registers and sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			mode_q   <= MODE_UPD;
			clr_q    <= '0;
			total_q  <= '0;
			min_q    <= MIN_TRACE_RESET;
			lrate_q  <= LRATE_RESET;
			tcnt_q   <= TCNT_RESET;
			loc_q    <= '0;
			done_q   <= 1'b0;
			status_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_LEARNING_RATE: lrate_q <= cfg_data;
					CFG_TILING_COUNT:  tcnt_q  <= cfg_data[10:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_CLR)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						status_q <= 1'b0;
						if (needs_idx && !in_range) begin
							status_q <= 1'b1;
							done_q   <= 1'b1;
						end else begin
							unique case (command)
								CMD_SET_TRACE, CMD_ADD_TRACE, CMD_CLEAR_TRACE,
								CMD_READ_WEIGHT, CMD_WRITE_WEIGHT: state_q <= S_FRD;
								CMD_DECAY: begin
									if (total_q == '0) begin
										done_q <= 1'b1;
									end else begin
										loc_q   <= last_loc;
										mode_q  <= MODE_DECAY;
										state_q <= S_LRD;
									end
								end
								CMD_UPDATE: begin
									if (total_q == '0) begin
										done_q <= 1'b1;
									end else begin
										loc_q   <= '0;
										mode_q  <= MODE_UPD;
										state_q <= S_LRD;
									end
								end
								default: done_q <= 1'b1;
							endcase
						end
					end
				end
				S_FRD: begin
					unique case (cmd_q)
						CMD_CLEAR_TRACE: begin
							if (frd_f.act) begin
								loc_q   <= frd_pos;
								total_q <= total_q - 1'b1;
								mode_q  <= MODE_CLEAR;
								state_q <= S_MV;
							end else begin
								state_q <= S_IDLE;
								done_q  <= 1'b1;
							end
						end
						CMD_SET_TRACE, CMD_ADD_TRACE: begin
							if (frd_f.act) begin
								state_q <= S_IDLE;
								done_q  <= 1'b1;
							end else begin
								state_q <= full ? S_ROOM : S_INS;
							end
						end
						default: begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end
					endcase
				end
				S_ROOM: begin
					if (!full) begin
						state_q <= S_INS;
					end else begin
						loc_q   <= last_loc;
						state_q <= S_LRD;
						if (min_q == TRACE_MAX) begin
							mode_q <= MODE_ROOM;
						end else begin
							mode_q <= MODE_CULL;
							min_q  <= raise_min(min_q);
						end
					end
				end
				S_INS: begin
					total_q <= total_q + 1'b1;
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				S_LRD: state_q <= S_SRD;
				S_SRD: begin
					if (drop_scan) begin
						total_q <= total_q - 1'b1;
						state_q <= S_MV;
					end else if (mode_q == MODE_UPD) begin
						state_q <= S_MUL;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_MUL: state_q <= S_DIV;
				S_DIV: begin
					if (div_done)
						state_q <= S_NEXT;
				end
				S_MV:  state_q <= S_MVF;
				S_MVF: state_q <= S_NEXT;
				S_NEXT: begin
					unique case (mode_q)
						MODE_CLEAR: begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end
						MODE_ROOM: state_q <= S_ROOM;
						MODE_DECAY, MODE_CULL: begin
							if (loc_q == '0) begin
								if (mode_q == MODE_CULL) begin
									state_q <= S_ROOM;
								end else begin
									state_q <= S_IDLE;
									done_q  <= 1'b1;
								end
							end else begin
								loc_q   <= loc_q - 1'b1;
								state_q <= S_LRD;
							end
						end
						MODE_UPD: begin
							if (CNT_W'(loc_q) + 1'b1 >= total_q) begin
								state_q <= S_IDLE;
								done_q  <= 1'b1;
							end else begin
								loc_q   <= loc_q + 1'b1;
								state_q <= S_LRD;
							end
						end
						default: ;
					endcase
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			cmd_q  <= command;
			f_q    <= idx_f;
			opnd_q <= operand;
			rate_q <= clamp16(34'(operand));
			da_q   <= 48'(operand) * 48'($signed({1'b0, lrate_q}));
			wout_q <= '0;
		end
		if (state_q == S_FRD) begin
			fw_q  <= frd;
			val_q <= new_val;
			if (cmd_q == CMD_READ_WEIGHT)
				wout_q <= frd_f.weight;
		end
		if (state_q == S_LRD)
			sf_q <= lrd;
		if (state_q == S_SRD) begin
			sw_q    <= frd;
			prod_s1 <= 64'(da_q) * 64'($signed({1'b0, frd_f.trace}));
		end
		if (state_q == S_MUL)
			neg_q <= prod_s1[63];
		if (state_q == S_MV)
			mv_q <= lrd;
	end

	// feature memory: weight, trace, active bit and list position
	sett_ram #(
		.WIDTH (FW_W),
		.DEPTH (STORE_DEPTH)
	) u_feat_ram (
		.clk   (clk),
		.we    (fw_en),
		.waddr (fw_addr),
		.wdata (fw_data),
		.raddr (fr_addr),
		.rdata (frd)
	);

	// active list of feature addresses
	sett_ram #(
		.WIDTH (FA_W),
		.DEPTH (MAX_ACTIVE)
	) u_list_ram (
		.clk   (clk),
		.we    (lw_en),
		.waddr (lw_addr),
		.wdata (lw_data),
		.raddr (lr_addr),
		.rdata (lrd)
	);

	sett_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign busy          = (state_q != S_IDLE);
	assign cfg_ready     = 1'b1;
	assign done          = done_q;
	assign weight_value  = wout_q;
	assign status        = status_q;
	assign active_count  = 11'(total_q);
	assign min_trace_now = min_q;

`ifndef SYNTHESIS
	// list never overfills
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= MAX_CNT) else $error("active total above list depth");

	// a result is only shown once the sequencer is back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE)) else $error("result strobe while busy");

	// the minimum threshold only ever rises
	a_min_rise: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (min_q >= $past(min_q))) else $error("minimum trace fell");

	// a divide is only started from the weight update walk
	a_div_upd: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (mode_q == MODE_UPD)) else $error("divide outside update");
`endif

endmodule
